### rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// Running sample statistics package
// Field widths, item types and the work item passed from the front end to
// the arithmetic back end.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 32;
    localparam int FRAC_BITS   = 8;
    localparam int SUM_BITS    = 48;
    localparam int SQ_BITS     = 62;
    localparam int PROD_BITS   = 94;
    localparam int VNUM_BITS   = PROD_BITS + FRAC_BITS;
    localparam int MNUM_BITS   = SUM_BITS + FRAC_BITS;
    localparam int DEN_BITS    = 2 * COUNT_BITS;
    localparam int MEAN_BITS   = 24;
    localparam int VAR_BITS    = 40;
    localparam int STD_BITS    = 24;
    localparam int ROOT_BITS   = 2 * STD_BITS;

    // Register byte addresses.
    localparam logic [2:0] ADDR_BESSEL = 3'd0;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          start_new;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]         count;
        logic signed [SAMPLE_BITS-1:0] minimum;
        logic signed [SAMPLE_BITS-1:0] maximum;
        logic signed [MEAN_BITS-1:0]   mean_q8;
        logic [VAR_BITS-1:0]           variance_q8;
        logic [STD_BITS-1:0]           std_dev_q8;
        logic                          full_res;
    } out_item_t;

    // Snapshot of the set after one sample, handed to the back end.
    typedef struct packed {
        logic [COUNT_BITS-1:0]         n;
        logic signed [SAMPLE_BITS-1:0] min_v;
        logic signed [SAMPLE_BITS-1:0] max_v;
        logic signed [SUM_BITS-1:0]    sum;
        logic [SQ_BITS-1:0]            sum_sq;
        logic                          bessel;
        logic                          full;
    } job_t;

endpackage

### rtl/running_sample_statistics.sv
// The back end works through one item at a time: a load step, the 80-step
// shift-add product, the 102-step variance divider, the 24-step square root
// and an output step that waits out any output stall. A set of one sample
// skips the divider. A two-entry queue accepts two further items meanwhile.
// Reset (aresetn low, synchronous) empties the set and turns Bessel correction on.
// ----------------------------------------------------------------------------
// Running sample statistics
// Count, minimum, maximum, mean, variance and standard deviation of a
// stream of signed samples, with an APB register for Bessel correction.
// ----------------------------------------------------------------------------
module running_sample_statistics (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rss_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rss_pkg::out_item_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic          bessel_reg;
    logic          take, q_ready, q_pop, q_not_full;
    rss_pkg::job_t front_job, head_job;

    assign pready  = 1'b1;
    assign prdata  = (paddr == rss_pkg::ADDR_BESSEL) ? {31'd0, bessel_reg} : 32'd0;
    assign s_ready = q_not_full;
    assign take    = s_valid && s_ready;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bessel_reg <= 1'b1;
        end else if (psel && penable && pwrite && (paddr == rss_pkg::ADDR_BESSEL)) begin
            bessel_reg <= pwdata[0];
        end
    end

    rss_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (s_data),
        .bessel  (bessel_reg),
        .job     (front_job)
    );

    rss_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (take),
        .push_job  (front_job),
        .pop       (q_pop),
        .head      (head_job),
        .not_empty (q_ready),
        .not_full  (q_not_full)
    );

    rss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_ready (q_ready),
        .job       (head_job),
        .job_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### rtl/rss_front.sv
// ----------------------------------------------------------------------------
// Running sample statistics front end
// Accepts samples, keeps count, min, max, sum and sum of squares, and emits
// one snapshot of the set per sample.
// ----------------------------------------------------------------------------
module rss_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  rss_pkg::in_item_t item,
    input  logic              bessel,
    output rss_pkg::job_t     job
);

    logic [rss_pkg::COUNT_BITS-1:0]         cnt_reg, cnt_next, base_cnt;
    logic signed [rss_pkg::SAMPLE_BITS-1:0] min_reg, min_next, base_min;
    logic signed [rss_pkg::SAMPLE_BITS-1:0] max_reg, max_next, base_max;
    logic signed [rss_pkg::SUM_BITS-1:0]    sum_reg, sum_next, base_sum;
    logic [rss_pkg::SQ_BITS-1:0]            sq_reg, sq_next, base_sq;
    logic [rss_pkg::SAMPLE_BITS-1:0]        mag;
    logic [2*rss_pkg::SAMPLE_BITS-1:0]      mag_sq;
    logic                                   is_full;

    localparam logic signed [rss_pkg::SAMPLE_BITS-1:0] MinInit =
        {1'b0, {(rss_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [rss_pkg::SAMPLE_BITS-1:0] MaxInit =
        {1'b1, {(rss_pkg::SAMPLE_BITS-1){1'b0}}};

    // A start flag clears the set before the sample is applied.
    always_comb begin
        base_cnt = item.start_new ? '0 : cnt_reg;
        base_min = item.start_new ? MinInit : min_reg;
        base_max = item.start_new ? MaxInit : max_reg;
        base_sum = item.start_new ? '0 : sum_reg;
        base_sq  = item.start_new ? '0 : sq_reg;
        is_full  = &base_cnt;
        mag      = item.sample[rss_pkg::SAMPLE_BITS-1] ?
                   (~item.sample + 1'b1) : item.sample;
        mag_sq   = mag * mag;

        cnt_next = base_cnt;
        min_next = base_min;
        max_next = base_max;
        sum_next = base_sum;
        sq_next  = base_sq;
        if (!is_full) begin
            cnt_next = base_cnt + 1'b1;
            min_next = (item.sample < base_min) ? item.sample : base_min;
            max_next = (item.sample > base_max) ? item.sample : base_max;
            sum_next = base_sum + {{(rss_pkg::SUM_BITS-rss_pkg::SAMPLE_BITS)
                                    {item.sample[rss_pkg::SAMPLE_BITS-1]}},
                                   item.sample};
            sq_next  = base_sq + {{(rss_pkg::SQ_BITS-2*rss_pkg::SAMPLE_BITS){1'b0}},
                                  mag_sq};
        end

        job.n      = cnt_next;
        job.min_v  = min_next;
        job.max_v  = max_next;
        job.sum    = sum_next;
        job.sum_sq = sq_next;
        job.bessel = bessel;
        job.full   = is_full;
    end

    // Accumulators.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            min_reg <= MinInit;
            max_reg <= MaxInit;
            sum_reg <= '0;
            sq_reg  <= '0;
        end else if (take) begin
            cnt_reg <= cnt_next;
            min_reg <= min_next;
            max_reg <= max_next;
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
        end
    end

endmodule

### rtl/rss_queue.sv
// ----------------------------------------------------------------------------
// Running sample statistics job queue
// Two-entry queue of set snapshots between the front end and the back end.
// ----------------------------------------------------------------------------
module rss_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rss_pkg::job_t push_job,
    input  logic          pop,
    output rss_pkg::job_t head,
    output logic          not_empty,
    output logic          not_full
);

    rss_pkg::job_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (fill_reg != 2'd0);
    assign not_full  = (fill_reg != 2'd2);

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/rss_back.sv
// ----------------------------------------------------------------------------
// Running sample statistics back end
// Shift-add products, two restoring dividers and a bit-pair square root turn
// one snapshot into mean, variance and standard deviation, then hold the
// result item in an output register.
// ----------------------------------------------------------------------------
module rss_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_ready,
    input  rss_pkg::job_t      job,
    output logic               job_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output rss_pkg::out_item_t m_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam int MulSteps  = rss_pkg::COUNT_BITS + rss_pkg::SUM_BITS;
    localparam int MeanSteps = rss_pkg::MNUM_BITS;
    localparam int DivSteps  = rss_pkg::VNUM_BITS;
    localparam int RootSteps = rss_pkg::STD_BITS;

    localparam logic [rss_pkg::MEAN_BITS-1:0] MeanNegMax =
        {1'b1, {(rss_pkg::MEAN_BITS-1){1'b0}}};
    localparam logic [rss_pkg::MEAN_BITS-1:0] MeanPosMax =
        {1'b0, {(rss_pkg::MEAN_BITS-1){1'b1}}};

    logic [2:0] state_reg;
    logic [6:0] step_reg;

    // Snapshot fields.
    logic [rss_pkg::COUNT_BITS-1:0]         n_reg;
    logic signed [rss_pkg::SAMPLE_BITS-1:0] min_reg, max_reg;
    logic [rss_pkg::SUM_BITS-1:0]           summ_reg;
    logic                                   neg_reg, full_reg;
    logic [rss_pkg::DEN_BITS-1:0]           den_reg;

    // Shift-add product of n*sum_sq - sum^2.
    logic [rss_pkg::PROD_BITS-1:0]          acc_reg, mc_reg;
    logic [rss_pkg::SUM_BITS-1:0]           mp_reg;

    // Mean divider.
    logic [rss_pkg::MNUM_BITS-1:0]          mnum_reg;
    logic [rss_pkg::COUNT_BITS:0]           mrem_reg, mrem_sh;
    logic [rss_pkg::MEAN_BITS:0]            mq_reg;
    logic                                   movf_reg, mge;

    // Variance divider.
    logic [rss_pkg::VNUM_BITS-1:0]          vnum_reg;
    logic [rss_pkg::DEN_BITS:0]             vrem_reg, vrem_sh;
    logic [rss_pkg::VAR_BITS:0]             vq_reg;
    logic                                   vovf_reg, vge;
    logic [rss_pkg::VAR_BITS-1:0]           var_reg, var_sat;

    // Square root.
    logic [rss_pkg::ROOT_BITS-1:0]          rx_reg, rres_reg, rbit_reg, rtry;

    logic                                   out_valid_reg;
    rss_pkg::out_item_t                     out_reg;
    logic [rss_pkg::SUM_BITS-1:0]           job_summ;
    logic [rss_pkg::COUNT_BITS-1:0]         job_d;
    logic [rss_pkg::MEAN_BITS-1:0]          mean_mag, mean_out;
    logic                                   mean_big;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign job_pop = (state_reg == ST_IDLE) && job_ready;

    // Per-step datapath terms.
    always_comb begin
        job_summ = job.sum[rss_pkg::SUM_BITS-1] ? (~job.sum + 1'b1) : job.sum;
        job_d    = job.bessel ? (job.n - 1'b1) : job.n;

        mrem_sh = {mrem_reg[rss_pkg::COUNT_BITS-1:0], mnum_reg[rss_pkg::MNUM_BITS-1]};
        mge     = (mrem_sh >= {1'b0, n_reg});
        vrem_sh = {vrem_reg[rss_pkg::DEN_BITS-1:0], vnum_reg[rss_pkg::VNUM_BITS-1]};
        vge     = (vrem_sh >= {1'b0, den_reg});
        // Quotient after the last divider step, saturated at the field width.
        var_sat = (vovf_reg || vq_reg[rss_pkg::VAR_BITS] || vq_reg[rss_pkg::VAR_BITS-1]) ?
                  '1 : {vq_reg[rss_pkg::VAR_BITS-2:0], vge};
        rtry    = rres_reg + rbit_reg;

        // Mean magnitude saturates at the signed field limits.
        mean_big = movf_reg || mq_reg[rss_pkg::MEAN_BITS];
        if (neg_reg) begin
            mean_mag = (mean_big || (mq_reg[rss_pkg::MEAN_BITS-1:0] > MeanNegMax)) ?
                       MeanNegMax : mq_reg[rss_pkg::MEAN_BITS-1:0];
            mean_out = ~mean_mag + 1'b1;
        end else begin
            mean_mag = (mean_big || mq_reg[rss_pkg::MEAN_BITS-1]) ?
                       MeanPosMax : mq_reg[rss_pkg::MEAN_BITS-1:0];
            mean_out = mean_mag;
        end
    end

    // Sequencer and control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // The output register fills at the end of a job and drains on acceptance.
            if ((state_reg == ST_OUT) && (!out_valid_reg || m_ready)) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (job_ready) begin
                        state_reg <= ST_MUL;
                        step_reg  <= '0;
                    end
                end
                ST_MUL: begin
                    if (step_reg == 7'(MulSteps - 1)) begin
                        step_reg  <= '0;
                        state_reg <= (n_reg < 2) ? ST_ROOT : ST_DIV;
                    end else begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                ST_DIV: begin
                    if (step_reg == 7'(DivSteps - 1)) begin
                        step_reg  <= '0;
                        state_reg <= ST_ROOT;
                    end else begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                ST_ROOT: begin
                    if (step_reg == 7'(RootSteps - 1)) begin
                        step_reg  <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                n_reg    <= job.n;
                min_reg  <= job.min_v;
                max_reg  <= job.max_v;
                full_reg <= job.full;
                neg_reg  <= job.sum[rss_pkg::SUM_BITS-1];
                summ_reg <= job_summ;
                den_reg  <= job.n * job_d;
                acc_reg  <= '0;
                mc_reg   <= {{(rss_pkg::PROD_BITS-rss_pkg::SQ_BITS){1'b0}}, job.sum_sq};
                mp_reg   <= {{(rss_pkg::SUM_BITS-rss_pkg::COUNT_BITS){1'b0}}, job.n};
                mnum_reg <= {job_summ, {rss_pkg::FRAC_BITS{1'b0}}};
                mrem_reg <= '0;
                mq_reg   <= '0;
                movf_reg <= 1'b0;
                var_reg  <= '0;
            end
            ST_MUL: begin
                // First n*sum_sq is added, then sum^2 is taken off.
                if (step_reg < 7'(rss_pkg::COUNT_BITS)) begin
                    if (mp_reg[0]) begin
                        acc_reg <= acc_reg + mc_reg;
                    end
                end else if (mp_reg[0]) begin
                    acc_reg <= acc_reg - mc_reg;
                end
                if (step_reg == 7'(rss_pkg::COUNT_BITS - 1)) begin
                    mc_reg <= {{(rss_pkg::PROD_BITS-rss_pkg::SUM_BITS){1'b0}}, summ_reg};
                    mp_reg <= summ_reg;
                end else begin
                    mc_reg <= mc_reg << 1;
                    mp_reg <= mp_reg >> 1;
                end
                // The mean division runs alongside the products.
                if (step_reg < 7'(MeanSteps)) begin
                    mrem_reg <= mge ? (mrem_sh - {1'b0, n_reg}) : mrem_sh;
                    mq_reg   <= {mq_reg[rss_pkg::MEAN_BITS-1:0], mge};
                    movf_reg <= movf_reg | mq_reg[rss_pkg::MEAN_BITS];
                    mnum_reg <= mnum_reg << 1;
                end
                vnum_reg <= {acc_reg, {rss_pkg::FRAC_BITS{1'b0}}};
                vrem_reg <= '0;
                vq_reg   <= '0;
                vovf_reg <= 1'b0;
                rx_reg   <= '0;
                rres_reg <= '0;
                rbit_reg <= {2'b01, {(rss_pkg::ROOT_BITS-2){1'b0}}};
            end
            ST_DIV: begin
                vrem_reg <= vge ? (vrem_sh - {1'b0, den_reg}) : vrem_sh;
                vq_reg   <= {vq_reg[rss_pkg::VAR_BITS-1:0], vge};
                vovf_reg <= vovf_reg | vq_reg[rss_pkg::VAR_BITS];
                vnum_reg <= vnum_reg << 1;
                if (step_reg == 7'(DivSteps - 1)) begin
                    var_reg <= var_sat;
                    rx_reg  <= {var_sat, {rss_pkg::FRAC_BITS{1'b0}}};
                end
            end
            ST_ROOT: begin
                if (rx_reg >= rtry) begin
                    rx_reg   <= rx_reg - rtry;
                    rres_reg <= (rres_reg >> 1) + rbit_reg;
                end else begin
                    rres_reg <= rres_reg >> 1;
                end
                rbit_reg <= rbit_reg >> 2;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_reg.count       <= n_reg;
                    out_reg.minimum     <= min_reg;
                    out_reg.maximum     <= max_reg;
                    out_reg.mean_q8     <= mean_out;
                    out_reg.variance_q8 <= var_reg;
                    out_reg.std_dev_q8  <= rres_reg[rss_pkg::STD_BITS-1:0];
                    out_reg.full_res    <= full_reg;
                end
            end
            default: begin
                var_reg <= var_sat;
            end
        endcase
    end

endmodule

### rtl/rss_checker.sv
// ----------------------------------------------------------------------------
// Running sample statistics port checker
// Watches the top level's result channel for consistency of its items.
// ----------------------------------------------------------------------------
module rss_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input rss_pkg::out_item_t m_data
);

    // A stalled result item holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // Every reported set holds at least one sample.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.count != '0)
        else $error("empty set reported");

    // The minimum never exceeds the maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.minimum <= m_data.maximum)
        else $error("minimum above maximum");

    // An ignored sample only happens at a saturated count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.full_res |-> &m_data.count)
        else $error("full flag without saturated count");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind running_sample_statistics rss_checker u_rss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### test/tb_running_sample_statistics.sv
// ----------------------------------------------------------------------------
// Running sample statistics testbench
// Drives signed samples through the valid/ready input channel, predicts
// count, min, max, mean, variance and standard deviation in exact integer
// arithmetic, and checks every result item in order. The Bessel register is
// written over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_running_sample_statistics;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 400;
    localparam logic [rss_pkg::COUNT_BITS-1:0] COUNT_SAT = '1;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    rss_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    rss_pkg::out_item_t m_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    running_sample_statistics u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predictor copy of the block state.
    logic [rss_pkg::COUNT_BITS-1:0]         set_count;
    logic signed [rss_pkg::SAMPLE_BITS-1:0] set_min;
    logic signed [rss_pkg::SAMPLE_BITS-1:0] set_max;
    logic signed [63:0]                     set_sum;
    logic [63:0]                            set_sum_sq;
    logic                                   bessel_on;

    rss_pkg::out_item_t pending_stats[$];
    int                 fail_count = 0;
    int                 idle_cycles = 0;
    bit                 sink_stalls = 1'b1;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bit_w;
        root = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > x) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (x >= root + bit_w) begin
                x = x - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    function automatic void clear_set();
        set_count = '0;
        set_min = 16'sh7FFF;
        set_max = -16'sh8000;
        set_sum = 0;
        set_sum_sq = 0;
    endfunction

    // Update the set with one sample and return the statistics it reports.
    function automatic rss_pkg::out_item_t fold_sample(input rss_pkg::in_item_t item);
        rss_pkg::out_item_t res;
        logic [63:0]  mag;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [63:0]  sum_abs;
        logic [63:0]  var_q;
        logic [63:0]  root;
        logic         full;
        full = 1'b0;
        if (item.start_new) clear_set();
        if (set_count == COUNT_SAT) begin
            full = 1'b1;
        end else begin
            set_count = set_count + 1;
            if (item.sample < set_min) set_min = item.sample;
            if (item.sample > set_max) set_max = item.sample;
            set_sum = set_sum + 64'(item.sample);
            mag = (item.sample < 0) ? 64'(-32'(item.sample)) : 64'(item.sample);
            set_sum_sq = set_sum_sq + mag * mag;
        end
        sum_abs = (set_sum < 0) ? 64'(-set_sum) : 64'(set_sum);
        quo = (128'(sum_abs) << rss_pkg::FRAC_BITS) / 128'(set_count);
        if (set_sum < 0) begin
            if (quo > 128'h80_0000) quo = 128'h80_0000;
            res.mean_q8 = 24'(-quo);
        end else begin
            if (quo > 128'h7F_FFFF) quo = 128'h7F_FFFF;
            res.mean_q8 = 24'(quo);
        end
        if (set_count < 2) begin
            var_q = 0;
        end else begin
            num = 128'(set_count) * 128'(set_sum_sq) - 128'(sum_abs) * 128'(sum_abs);
            den = 128'(set_count) * 128'(bessel_on ? set_count - 1 : set_count);
            quo = (num << rss_pkg::FRAC_BITS) / den;
            var_q = (quo > 128'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : 64'(quo);
        end
        root = floor_sqrt(var_q << rss_pkg::FRAC_BITS);
        if (root > 64'hFF_FFFF) root = 64'hFF_FFFF;
        res.count = set_count;
        res.minimum = set_min;
        res.maximum = set_max;
        res.variance_q8 = 40'(var_q);
        res.std_dev_q8 = 24'(root);
        res.full_res = full;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        fail_count++;
    endtask

    // Result checker and acceptance tracking.
    always @(posedge aclk) begin
        rss_pkg::out_item_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (pending_stats.size() == 0) begin
                    report_mismatch("unexpected result item", 64'(m_data.count), 0);
                end else begin
                    want = pending_stats.pop_front();
                    if (m_data.count !== want.count)
                        report_mismatch("count", m_data.count, want.count);
                    if (m_data.minimum !== want.minimum)
                        report_mismatch("minimum", m_data.minimum, want.minimum);
                    if (m_data.maximum !== want.maximum)
                        report_mismatch("maximum", m_data.maximum, want.maximum);
                    if (m_data.mean_q8 !== want.mean_q8)
                        report_mismatch("mean", m_data.mean_q8, want.mean_q8);
                    if (m_data.variance_q8 !== want.variance_q8)
                        report_mismatch("variance", m_data.variance_q8,
                                        want.variance_q8);
                    if (m_data.std_dev_q8 !== want.std_dev_q8)
                        report_mismatch("std_dev", m_data.std_dev_q8, want.std_dev_q8);
                    if (m_data.full_res !== want.full_res)
                        report_mismatch("full", m_data.full_res, want.full_res);
                end
            end
        end
    end

    // Receiver: random stall bursts until the last part of the run.
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                gap = $urandom_range(1, 15);
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        bessel_on = value[0];
    endtask

    task automatic wait_drained();
        while (pending_stats.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Offer one item, predict at acceptance, optionally idle first.
    task automatic send_sample(input logic signed [rss_pkg::SAMPLE_BITS-1:0] value,
                               input logic start, input bit gaps);
        rss_pkg::in_item_t item;
        int gap;
        if (gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge aclk);
        end
        item.sample = value;
        item.start_new = start;
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_stats.push_back(fold_sample(item));
        @(negedge aclk);
    endtask

    // Directed table: sample, start flag, typed-in expected fields where obvious.
    typedef struct {
        logic signed [15:0] sample;
        logic               start;
        bit                 typed;
        logic [31:0]        count;
        logic [39:0]        variance;
    } directed_row_t;

    directed_row_t directed_rows[] = '{
        '{16'sh7FFF, 1'b1, 1, 32'd1, 40'd0},
        '{-16'sh8000, 1'b0, 0, 0, 0},
        '{16'sh0000, 1'b0, 0, 0, 0},
        '{-16'sh0001, 1'b1, 1, 32'd1, 40'd0},
        '{16'sh0001, 1'b0, 0, 0, 0},
        '{16'sh5555, 1'b0, 0, 0, 0},
        '{-16'sh5556, 1'b0, 0, 0, 0},
        '{16'sh0000, 1'b1, 1, 32'd1, 40'd0},
        '{16'sh0000, 1'b0, 1, 32'd2, 40'd0},
        '{-16'sh8000, 1'b1, 1, 32'd1, 40'd0},
        '{-16'sh8000, 1'b0, 1, 32'd2, 40'd0},
        '{16'sh7FFF, 1'b0, 0, 0, 0},
        '{16'sh1234, 1'b0, 0, 0, 0}
    };

    initial begin
        rss_pkg::out_item_t want;
        int set_len;
        int budget;
        bit paused_once;
        paused_once = 1'b0;
        bessel_on = 1'b1;
        clear_set();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed phase with Bessel correction after reset, then without.
        for (int pass = 0; pass < 2; pass++) begin
            foreach (directed_rows[i]) begin
                send_sample(directed_rows[i].sample, directed_rows[i].start, 0);
                want = pending_stats[$];
                if (directed_rows[i].typed) begin
                    if (want.count !== directed_rows[i].count ||
                        want.variance_q8 !== directed_rows[i].variance)
                        report_mismatch("table row", i, directed_rows[i].count);
                end
            end
            s_valid <= 1'b0;
            wait_drained();
            apb_write(rss_pkg::ADDR_BESSEL, {31'd0, bessel_on ? 1'b0 : 1'b1});
        end

        // Random phases with sets of varied length and mostly well-formed values.
        for (int phase = 0; phase < 4; phase++) begin
            budget = 220;
            while (budget > 0) begin
                set_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                       : $urandom_range(2, 30);
                for (int k = 0; k < set_len && budget > 0; k++) begin
                    logic signed [15:0] v;
                    case ($urandom_range(0, 4))
                        0: v = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
                        1: v = 16'($urandom_range(0, 20)) - 16'sd10;
                        default: v = 16'($urandom);
                    endcase
                    send_sample(v, k == 0 ? 1'b1 : ($urandom_range(0, 40) == 0), phase < 3);
                    budget--;
                end
                // Once in the run the sender waits until every result is back.
                if (phase == 1 && budget <= 110 && !paused_once) begin
                    paused_once = 1'b1;
                    s_valid <= 1'b0;
                    while (pending_stats.size() != 0) @(negedge aclk);
                end
            end
            s_valid <= 1'b0;
            if (phase == 2) sink_stalls = 1'b0;
            wait_drained();
            apb_write(rss_pkg::ADDR_BESSEL, {31'd0, 1'(phase[0])});
        end

        wait_drained();
        if (fail_count == 0 && pending_stats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
